[design/qoi_pkg.sv]
// ----------------------------------------------------------------------------
// qoi_pkg: shared types and constants of the quaternion orientation integrator
// Payload structs, command codes, controller-to-datapath command and status
// structs, and the table of product terms.
// ----------------------------------------------------------------------------
`default_nettype none

package qoi_pkg;

    localparam logic [1:0] CMD_INTEG  = 2'd0;
    localparam logic [1:0] CMD_ROTATE = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;

    localparam logic signed [31:0] Q_ONE = 32'sh2000_0000;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic [23:0]        step_time;
        logic signed [31:0] load_w;
        logic signed [31:0] load_x;
        logic signed [31:0] load_y;
        logic signed [31:0] load_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic               zero_norm;
    } out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_TERM,
        OP_ACC_TERM,
        OP_MUL_DT,
        OP_ADD_DT,
        OP_MUL_SQ,
        OP_ADD_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_STORE,
        OP_LOAD,
        OP_COMMIT
    } op_t;

    typedef struct packed {
        logic       capture;
        op_t        op;
        logic [3:0] idx;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] command;
        logic       norm_zero;
    } status_t;

    // One product term: vector component, quaternion component, sign, and
    // where it falls in the three-term sum of its result component.
    typedef struct packed {
        logic [1:0] vsel;
        logic [1:0] qsel;
        logic       neg;
        logic       first;
        logic       last;
        logic [1:0] comp;
    } term_t;

    function automatic term_t term_info(input logic rotate, input logic [3:0] idx);
        term_t t;
        t = '0;
        case (idx)
            4'd0:  t = '{2'd0, 2'd1, 1'b1, 1'b1, 1'b0, 2'd0};
            4'd1:  t = '{2'd1, 2'd2, 1'b1, 1'b0, 1'b0, 2'd0};
            4'd2:  t = '{2'd2, 2'd3, 1'b1, 1'b0, 1'b1, 2'd0};
            4'd3:  t = '{2'd0, 2'd0, 1'b0, 1'b1, 1'b0, 2'd1};
            4'd4:  t = rotate ? '{2'd2, 2'd2, 1'b0, 1'b0, 1'b0, 2'd1}
                              : '{2'd1, 2'd3, 1'b0, 1'b0, 1'b0, 2'd1};
            4'd5:  t = rotate ? '{2'd1, 2'd3, 1'b1, 1'b0, 1'b1, 2'd1}
                              : '{2'd2, 2'd2, 1'b1, 1'b0, 1'b1, 2'd1};
            4'd6:  t = '{2'd1, 2'd0, 1'b0, 1'b1, 1'b0, 2'd2};
            4'd7:  t = rotate ? '{2'd0, 2'd3, 1'b0, 1'b0, 1'b0, 2'd2}
                              : '{2'd2, 2'd1, 1'b0, 1'b0, 1'b0, 2'd2};
            4'd8:  t = rotate ? '{2'd2, 2'd1, 1'b1, 1'b0, 1'b1, 2'd2}
                              : '{2'd0, 2'd3, 1'b1, 1'b0, 1'b1, 2'd2};
            4'd9:  t = '{2'd2, 2'd0, 1'b0, 1'b1, 1'b0, 2'd3};
            4'd10: t = rotate ? '{2'd1, 2'd1, 1'b0, 1'b0, 1'b0, 2'd3}
                              : '{2'd0, 2'd2, 1'b0, 1'b0, 1'b0, 2'd3};
            4'd11: t = rotate ? '{2'd0, 2'd2, 1'b1, 1'b0, 1'b1, 2'd3}
                              : '{2'd1, 2'd1, 1'b1, 1'b0, 1'b1, 2'd3};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/qoi_datapath.sv]
// ----------------------------------------------------------------------------
// qoi_datapath: arithmetic and storage of the orientation integrator
// Shared multiplier, term accumulator, bit-serial square root and divider,
// orientation state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire qoi_pkg::in_t   s_data,
    input  wire qoi_pkg::ctrl_t ctrl,
    output qoi_pkg::status_t    status,
    output qoi_pkg::out_t       m_data
);

    qoi_pkg::in_t       item_reg;
    logic signed [31:0] orient_reg [4];
    logic signed [31:0] work_reg   [4];
    logic signed [65:0] prod_reg;
    logic signed [49:0] acc_reg;
    logic [64:0]        sumsq_reg;
    logic [63:0]        rad_reg;
    logic [34:0]        srem_reg;
    logic [31:0]        root_reg;
    logic               wrap_reg;
    logic [33:0]        drem_reg;
    logic [31:0]        dsh_reg;
    logic [31:0]        quo_reg;
    logic               ovf_reg;
    logic               dneg_reg;
    qoi_pkg::out_t      out_reg;

    qoi_pkg::term_t     term;
    logic signed [31:0] vec_sel;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_next;
    logic signed [49:0] term_val;
    logic signed [49:0] acc_base;
    logic signed [49:0] acc_next;
    logic [1:0]         j;
    logic [32:0]        norm;
    logic [34:0]        srem_sh;
    logic [34:0]        strial;
    logic [31:0]        mag;
    logic [33:0]        drem_sh;
    logic               dge;
    logic signed [63:0] dt_sum;
    logic [31:0]        div_res;

    assign j    = ctrl.idx[1:0];
    assign term = qoi_pkg::term_info(item_reg.command == qoi_pkg::CMD_ROTATE, ctrl.idx);
    assign norm = wrap_reg ? {1'b1, 32'd0} : {1'b0, root_reg};

    always_comb begin
        case (term.vsel)
            2'd0:    vec_sel = item_reg.vec_x;
            2'd1:    vec_sel = item_reg.vec_y;
            default: vec_sel = item_reg.vec_z;
        endcase
        case (ctrl.op)
            qoi_pkg::OP_MUL_TERM: begin
                mul_a = 33'(vec_sel);
                mul_b = 33'(orient_reg[term.qsel]);
            end
            qoi_pkg::OP_MUL_DT: begin
                mul_a = 33'(work_reg[j]);
                mul_b = $signed({9'd0, item_reg.step_time});
            end
            default: begin
                mul_a = 33'(work_reg[j]);
                mul_b = 33'(work_reg[j]);
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Floor shift by 16 for vector-by-component products
    assign term_val = $signed(prod_reg[65:16]);
    assign acc_base = term.first ? '0 : acc_reg;
    assign acc_next = term.neg ? acc_base - term_val : acc_base + term_val;

    // Floor shift by 25: dt fraction plus the halving
    assign dt_sum = 64'(orient_reg[j]) + 64'($signed(prod_reg[65:25]));

    assign srem_sh = {srem_reg[32:0], rad_reg[63:62]};
    assign strial  = {1'b0, root_reg, 2'b01};

    assign mag     = work_reg[j][31] ? 32'(-work_reg[j]) : work_reg[j];
    assign drem_sh = {drem_reg[32:0], dsh_reg[31]};
    assign dge     = drem_sh >= {1'b0, norm};

    always_comb begin
        if (dneg_reg) begin
            div_res = (ovf_reg || quo_reg[31]) ? 32'h8000_0000 : -quo_reg;
        end else begin
            div_res = (ovf_reg || quo_reg[31]) ? 32'h7FFF_FFFF : quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg[0] <= qoi_pkg::Q_ONE;
            orient_reg[1] <= '0;
            orient_reg[2] <= '0;
            orient_reg[3] <= '0;
        end else if (ctrl.op == qoi_pkg::OP_COMMIT) begin
            orient_reg <= work_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            item_reg  <= s_data;
            work_reg  <= orient_reg;
            sumsq_reg <= '0;
        end
        case (ctrl.op)
            qoi_pkg::OP_MUL_TERM, qoi_pkg::OP_MUL_DT, qoi_pkg::OP_MUL_SQ: begin
                prod_reg <= prod_next;
            end
            qoi_pkg::OP_ACC_TERM: begin
                acc_reg <= acc_next;
                if (term.last) begin
                    work_reg[term.comp] <= qoi_pkg::sat32(64'(acc_next));
                end
            end
            qoi_pkg::OP_ADD_DT: begin
                work_reg[j] <= qoi_pkg::sat32(dt_sum);
            end
            qoi_pkg::OP_ADD_SQ: begin
                sumsq_reg <= sumsq_reg + {1'b0, prod_reg[63:0]};
            end
            qoi_pkg::OP_SQRT_INIT: begin
                wrap_reg <= sumsq_reg[64];
                rad_reg  <= sumsq_reg[63:0];
                srem_reg <= '0;
                root_reg <= '0;
            end
            qoi_pkg::OP_SQRT_STEP: begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                if (srem_sh >= strial) begin
                    srem_reg <= srem_sh - strial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    srem_reg <= srem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            qoi_pkg::OP_DIV_INIT: begin
                drem_reg <= {5'd0, mag[31:3]};
                dsh_reg  <= {mag[2:0], 29'd0};
                quo_reg  <= '0;
                ovf_reg  <= {4'd0, mag[31:3]} >= norm;
                dneg_reg <= work_reg[j][31];
            end
            qoi_pkg::OP_DIV_STEP: begin
                dsh_reg  <= {dsh_reg[30:0], 1'b0};
                drem_reg <= dge ? drem_sh - {1'b0, norm} : drem_sh;
                quo_reg  <= {quo_reg[30:0], dge};
            end
            qoi_pkg::OP_DIV_STORE: begin
                work_reg[j] <= div_res;
            end
            qoi_pkg::OP_LOAD: begin
                work_reg[0] <= item_reg.load_w;
                work_reg[1] <= item_reg.load_x;
                work_reg[2] <= item_reg.load_y;
                work_reg[3] <= item_reg.load_z;
            end
            qoi_pkg::OP_COMMIT: begin
                out_reg.quat_w    <= work_reg[0];
                out_reg.quat_x    <= work_reg[1];
                out_reg.quat_y    <= work_reg[2];
                out_reg.quat_z    <= work_reg[3];
                out_reg.zero_norm <= (item_reg.command == qoi_pkg::CMD_INTEG ||
                                      item_reg.command == qoi_pkg::CMD_ROTATE) &&
                                     (norm == '0);
            end
            default: begin
            end
        endcase
    end

    assign status.command   = item_reg.command;
    assign status.norm_zero = (norm == '0);
    assign m_data           = out_reg;

endmodule

`default_nettype wire

[design/qoi_ctrl.sv]
// ----------------------------------------------------------------------------
// qoi_ctrl: sequencer of the orientation integrator
// Steps the datapath through products, step scaling, squares, square root
// and division, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire qoi_pkg::status_t status,
    output qoi_pkg::ctrl_t        ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_TMUL, ST_TACC, ST_DMUL, ST_DADD, ST_SMUL,
        ST_SADD, ST_RINIT, ST_RSTEP, ST_RCHK, ST_DINIT, ST_DSTEP, ST_DSTORE,
        ST_LOAD, ST_FIN
    } state_t;

    state_t     state_reg;
    logic [3:0] idx_reg;
    logic [4:0] cnt_reg;
    logic       m_valid_reg;
    logic       room;

    // Hold off the input while reset is applied
    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign room    = !m_valid_reg || m_ready;

    always_comb begin
        ctrl.capture = s_valid && s_ready;
        ctrl.idx     = idx_reg;
        case (state_reg)
            ST_TMUL:   ctrl.op = qoi_pkg::OP_MUL_TERM;
            ST_TACC:   ctrl.op = qoi_pkg::OP_ACC_TERM;
            ST_DMUL:   ctrl.op = qoi_pkg::OP_MUL_DT;
            ST_DADD:   ctrl.op = qoi_pkg::OP_ADD_DT;
            ST_SMUL:   ctrl.op = qoi_pkg::OP_MUL_SQ;
            ST_SADD:   ctrl.op = qoi_pkg::OP_ADD_SQ;
            ST_RINIT:  ctrl.op = qoi_pkg::OP_SQRT_INIT;
            ST_RSTEP:  ctrl.op = qoi_pkg::OP_SQRT_STEP;
            ST_DINIT:  ctrl.op = qoi_pkg::OP_DIV_INIT;
            ST_DSTEP:  ctrl.op = qoi_pkg::OP_DIV_STEP;
            ST_DSTORE: ctrl.op = qoi_pkg::OP_DIV_STORE;
            ST_LOAD:   ctrl.op = qoi_pkg::OP_LOAD;
            ST_FIN:    ctrl.op = room ? qoi_pkg::OP_COMMIT : qoi_pkg::OP_NONE;
            default:   ctrl.op = qoi_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    if (s_valid) begin
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    if (status.command == qoi_pkg::CMD_INTEG ||
                        status.command == qoi_pkg::CMD_ROTATE) begin
                        state_reg <= ST_TMUL;
                    end else if (status.command == qoi_pkg::CMD_LOAD) begin
                        state_reg <= ST_LOAD;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_TMUL: state_reg <= ST_TACC;
                ST_TACC: begin
                    if (idx_reg == 4'd11) begin
                        idx_reg   <= '0;
                        state_reg <= (status.command == qoi_pkg::CMD_INTEG) ? ST_DMUL
                                                                            : ST_SMUL;
                    end else begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= ST_TMUL;
                    end
                end
                ST_DMUL: state_reg <= ST_DADD;
                ST_DADD: begin
                    if (idx_reg == 4'd3) begin
                        idx_reg   <= '0;
                        state_reg <= ST_SMUL;
                    end else begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= ST_DMUL;
                    end
                end
                ST_SMUL: state_reg <= ST_SADD;
                ST_SADD: begin
                    if (idx_reg == 4'd3) begin
                        idx_reg   <= '0;
                        state_reg <= ST_RINIT;
                    end else begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= ST_SMUL;
                    end
                end
                ST_RINIT: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_RSTEP;
                end
                ST_RSTEP: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= ST_RCHK;
                    end
                end
                ST_RCHK: begin
                    state_reg <= status.norm_zero ? ST_FIN : ST_DINIT;
                end
                ST_DINIT: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DSTEP;
                end
                ST_DSTEP: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= ST_DSTORE;
                    end
                end
                ST_DSTORE: begin
                    if (idx_reg == 4'd3) begin
                        state_reg <= ST_FIN;
                    end else begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= ST_DINIT;
                    end
                end
                ST_LOAD: state_reg <= ST_FIN;
                ST_FIN: begin
                    if (room) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_DISPATCH)
        else $error("accepted transaction did not enter dispatch");

    a_fin_publish: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && room |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not published");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DSTEP |=> state_reg == ST_DSTEP || state_reg == ST_DSTORE)
        else $error("division left early");

endmodule

`default_nettype wire

[design/quaternion_orientation_integrator_core.sv]
// ----------------------------------------------------------------------------
// quaternion_orientation_integrator_core: first-order attitude integrator
// Keeps an orientation quaternion in Q2.29 and updates it one transaction at
// a time: integrate an angular rate, rotate by a vector, or load.
// ----------------------------------------------------------------------------
// One transaction at a time. When the norm is zero the four divisions are
// skipped. Input ready returns in the same cycle as the result is
// published. The arithmetic runs on one shared 33x33 multiplier (12
// product terms, 4 step scalings on integrate and 4 squares), a 32-step
// bit-serial square root of the sum of squares, and a 32-step restoring
// divider run once per component. A finished result sits in the output
// register while the next transaction is accepted and computed; if it is
// still waiting when the next result is ready, hold there and stall the
// input. The orientation resets to (1,0,0,0); if the norm is zero the
// quaternion is left as computed and zero_norm is raised.
`default_nettype none

module quaternion_orientation_integrator_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire qoi_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output qoi_pkg::out_t      m_data
);

    // Command and status between the sequencer and the datapath
    qoi_pkg::ctrl_t   ctrl;
    qoi_pkg::status_t status;

    // Sequence each transaction and own both handshakes
    qoi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Hold the orientation and do the arithmetic
    qoi_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[tb/quaternion_orientation_integrator_core_tb.sv]
// ----------------------------------------------------------------------------
// quaternion_orientation_integrator_core_tb: self-checking testbench
// Drives integrate, rotate, load and unused commands through the valid/ready
// input channel, predicts each new orientation with a fixed-point model of the
// attitude update, and checks every result transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_orientation_integrator_core_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    qoi_pkg::in_t   s_data;
    logic           m_valid;
    logic           m_ready;
    qoi_pkg::out_t  m_data;

    // Orientation as the predictor sees it.
    logic signed [31:0] attitude [4];
    qoi_pkg::out_t      expected_quats [$];

    int unsigned cycle_count;
    int          mismatch_count;
    int          orphan_count;
    int          items_sent;
    int          results_checked;
    int          zero_norm_seen;
    int          hold_off_cycles;

    quaternion_orientation_integrator_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Fixed-point attitude arithmetic
    // ------------------------------------------------------------------

    // Clamp to the Q2.29 range.
    function automatic logic signed [31:0] clamp_q229(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q16.16 vector times Q2.29 component, floored back to Q.29.
    function automatic logic signed [63:0] rate_term(input logic signed [31:0] v,
                                                     input logic signed [31:0] c);
        logic signed [63:0] a;
        logic signed [63:0] b;
        a = v;
        b = c;
        return (a * b) >>> 16;
    endfunction

    function automatic logic [65:0] floor_sqrt(input logic [65:0] s);
        logic [65:0] rem;
        logic [65:0] root;
        logic [65:0] probe;
        int k;
        rem   = s;
        root  = '0;
        probe = 66'd1 << 64;
        for (k = 0; k < 33; k++) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Apply one command to the predicted attitude and return the result.
    function automatic qoi_pkg::out_t predict_attitude(input qoi_pkg::in_t d);
        logic signed [31:0] nq [4];
        logic signed [31:0] prod [4];
        logic signed [63:0] dt;
        logic signed [63:0] pv;
        logic [65:0]        sumsq;
        logic [63:0]        mag;
        logic [63:0]        norm;
        logic [63:0]        quo;
        logic signed [63:0] sq;
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zn;
        logic               renorm;
        qoi_pkg::out_t      r;
        int                 i;
        w = attitude[0];
        x = attitude[1];
        y = attitude[2];
        z = attitude[3];
        for (i = 0; i < 4; i++) nq[i] = attitude[i];
        zn = 1'b0;
        renorm = 1'b0;
        dt = {40'd0, d.step_time};
        case (d.command)
            qoi_pkg::CMD_INTEG: begin
                prod[0] = clamp_q229(-rate_term(d.vec_x, x) - rate_term(d.vec_y, y)
                                     - rate_term(d.vec_z, z));
                prod[1] = clamp_q229(rate_term(d.vec_x, w) + rate_term(d.vec_y, z)
                                     - rate_term(d.vec_z, y));
                prod[2] = clamp_q229(rate_term(d.vec_y, w) + rate_term(d.vec_z, x)
                                     - rate_term(d.vec_x, z));
                prod[3] = clamp_q229(rate_term(d.vec_z, w) + rate_term(d.vec_x, y)
                                     - rate_term(d.vec_y, x));
                for (i = 0; i < 4; i++) begin
                    pv = prod[i];
                    sq = attitude[i];
                    nq[i] = clamp_q229(sq + ((pv * dt) >>> 25));
                end
                renorm = 1'b1;
            end
            qoi_pkg::CMD_ROTATE: begin
                nq[0] = clamp_q229(-rate_term(d.vec_x, x) - rate_term(d.vec_y, y)
                                   - rate_term(d.vec_z, z));
                nq[1] = clamp_q229(rate_term(d.vec_x, w) + rate_term(d.vec_z, y)
                                   - rate_term(d.vec_y, z));
                nq[2] = clamp_q229(rate_term(d.vec_y, w) + rate_term(d.vec_x, z)
                                   - rate_term(d.vec_z, x));
                nq[3] = clamp_q229(rate_term(d.vec_z, w) + rate_term(d.vec_y, x)
                                   - rate_term(d.vec_x, y));
                renorm = 1'b1;
            end
            qoi_pkg::CMD_LOAD: begin
                nq[0] = d.load_w;
                nq[1] = d.load_x;
                nq[2] = d.load_y;
                nq[3] = d.load_z;
            end
            default: begin
            end
        endcase
        if (renorm) begin
            // Exact sum of squares; all four at -2^31 gives 2^64, root 2^32.
            sumsq = '0;
            for (i = 0; i < 4; i++) begin
                sq = nq[i];
                mag = (sq < 0) ? 64'(-sq) : 64'(sq);
                sumsq = sumsq + 66'(mag * mag);
            end
            norm = 64'(floor_sqrt(sumsq));
            if (norm == 0) begin
                zn = 1'b1;
            end else begin
                for (i = 0; i < 4; i++) begin
                    sq = nq[i];
                    mag = (sq < 0) ? 64'(-sq) : 64'(sq);
                    quo = (mag << 29) / norm;
                    if (quo > 64'h8000_0000) quo = 64'h8000_0000;
                    pv = quo;
                    nq[i] = clamp_q229((sq < 0) ? -pv : pv);
                end
            end
        end
        for (i = 0; i < 4; i++) attitude[i] = nq[i];
        r.quat_w    = nq[0];
        r.quat_x    = nq[1];
        r.quat_y    = nq[2];
        r.quat_z    = nq[3];
        r.zero_norm = zn;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int g;
        if ($urandom_range(0, 19) == 0) begin
            g = $urandom_range(20, 80);
        end else if ($urandom_range(0, 2) == 0) begin
            g = 0;
        end else begin
            g = $urandom_range(1, 4);
        end
        return g;
    endfunction

    // Hold valid and payload until accepted; leave valid high afterwards so
    // a back-to-back transaction keeps it up without a glitch.
    task automatic send_command(input qoi_pkg::in_t d, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        expected_quats.push_back(predict_attitude(d));
        items_sent++;
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        go_idle();
        while (expected_quats.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_word();
        return $urandom();
    endfunction

    // Angular rate of a few rad/s in Q16.16, or any pattern now and then.
    function automatic logic signed [31:0] rand_rate();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = rand_word();
            1:       v = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            default: v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
        return v;
    endfunction

    // Component near the unit sphere in Q2.29, or any pattern.
    function automatic logic signed [31:0] rand_comp();
        logic signed [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = rand_word();
            1:       v = '0;
            default: v = $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
        endcase
        return v;
    endfunction

    function automatic qoi_pkg::in_t make_item(input logic [1:0] cmd);
        qoi_pkg::in_t d;
        d.command   = cmd;
        d.vec_x     = rand_rate();
        d.vec_y     = rand_rate();
        d.vec_z     = rand_rate();
        d.step_time = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                                                  : 24'($urandom_range(0, 24'h0A_0000));
        d.load_w    = rand_comp();
        d.load_x    = rand_comp();
        d.load_y    = rand_comp();
        d.load_z    = rand_comp();
        // Zero vector now and then: rotate then collapses to a zero quaternion.
        if ($urandom_range(0, 24) == 0) begin
            d.vec_x = '0;
            d.vec_y = '0;
            d.vec_z = '0;
        end
        return d;
    endfunction

    function automatic qoi_pkg::in_t load_item(input logic signed [31:0] w,
                                               input logic signed [31:0] x,
                                               input logic signed [31:0] y,
                                               input logic signed [31:0] z);
        qoi_pkg::in_t d;
        d = make_item(qoi_pkg::CMD_LOAD);
        d.load_w = w;
        d.load_x = x;
        d.load_y = y;
        d.load_z = z;
        return d;
    endfunction

    function automatic qoi_pkg::in_t vec_item(input logic [1:0] cmd,
                                              input logic signed [31:0] vx,
                                              input logic signed [31:0] vy,
                                              input logic signed [31:0] vz,
                                              input logic [23:0] dt);
        qoi_pkg::in_t d;
        d = make_item(cmd);
        d.vec_x     = vx;
        d.vec_y     = vy;
        d.vec_z     = vz;
        d.step_time = dt;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_corners();
        // Unused command on the reset attitude, then a plain integrate step.
        send_command(make_item(CMD_UNUSED), 2);
        send_command(vec_item(qoi_pkg::CMD_INTEG, 32'sh0001_0000, 32'sh0, 32'sh0,
                              24'h01_0000), 0);
        send_command(vec_item(qoi_pkg::CMD_INTEG, 32'sh7FFF_FFFF, 32'sh8000_0000,
                              32'sh7FFF_FFFF, 24'hFF_FFFF), 1);
        send_command(vec_item(qoi_pkg::CMD_ROTATE, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh8000_0000, 24'h0), 0);
        // Zero quaternion: both normalizing commands must skip and flag.
        send_command(load_item(32'sh0, 32'sh0, 32'sh0, 32'sh0), 3);
        send_command(vec_item(qoi_pkg::CMD_INTEG, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                              32'sh7FFF_FFFF, 24'hFF_FFFF), 0);
        send_command(vec_item(qoi_pkg::CMD_ROTATE, 32'sh0001_0000, 32'sh0, 32'sh0,
                              24'h0), 0);
        // Largest sum of squares: every component at the negative limit.
        send_command(load_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh8000_0000), 0);
        send_command(vec_item(qoi_pkg::CMD_INTEG, 32'sh0, 32'sh0, 32'sh0,
                              24'hFF_FFFF), 0);
        send_command(load_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                               32'sh7FFF_FFFF), 2);
        send_command(vec_item(qoi_pkg::CMD_INTEG, 32'sh0, 32'sh0, 32'sh0, 24'h0), 0);
        send_command(vec_item(qoi_pkg::CMD_ROTATE, 32'sh7FFF_FFFF, 32'sh8000_0000,
                              32'sh0001_0000, 24'hFF_FFFF), 0);
        // Zero vector on a unit quaternion collapses rotate to zero.
        send_command(load_item(qoi_pkg::Q_ONE, 32'sh0, 32'sh0, 32'sh0), 0);
        send_command(vec_item(qoi_pkg::CMD_ROTATE, 32'sh0, 32'sh0, 32'sh0, 24'h0), 1);
        send_command(load_item(32'sh0, 32'sh8000_0000, 32'sh0, 32'sh7FFF_FFFF), 0);
        send_command(vec_item(qoi_pkg::CMD_ROTATE, 32'sh0, 32'sh0, 32'sh0001_0000,
                              24'h0), 0);
        send_command(vec_item(qoi_pkg::CMD_INTEG, 32'shFFFF_0000, 32'sh0002_0000,
                              32'sh8000_0000, 24'h80_0000), 0);
        send_command(make_item(CMD_UNUSED), 0);
        send_command(load_item(qoi_pkg::Q_ONE, 32'sh0, 32'sh0, 32'sh0), 5);
        wait_drained();
    endtask

    // Mostly integrate/rotate streams with realistic content, a few loads and
    // unused commands to move the attitude somewhere new.
    task automatic test_random_stream(input int count);
        logic [1:0] cmd;
        int n;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0, 1:    cmd = qoi_pkg::CMD_LOAD;
                2:       cmd = CMD_UNUSED;
                3, 4, 5: cmd = qoi_pkg::CMD_ROTATE;
                default: cmd = qoi_pkg::CMD_INTEG;
            endcase
            send_command(make_item(cmd), pick_gap());
        end
    endtask

    // Receiver stalls for a long stretch while items keep coming.
    task automatic test_receiver_hold_off();
        int n;
        hold_off_cycles = 2500;
        for (n = 0; n < 8; n++) send_command(make_item(2'($urandom_range(0, 3))), 0);
        wait_drained();
    endtask

    // Sender pauses until every result is back, then resumes.
    task automatic test_sender_pause();
        test_random_stream(20);
        wait_drained();
        repeat (50) @(posedge aclk);
        test_random_stream(20);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back pressure, plus the requested hold-off
    // ------------------------------------------------------------------
    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (hold_off_cycles > 0) begin
            m_ready         <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        qoi_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_quats.size() == 0) begin
                orphan_count++;
                if (mismatch_count + orphan_count <= MAX_REPORTS) begin
                    $display("unexpected result transaction: %p", m_data);
                end
            end else begin
                want = expected_quats.pop_front();
                results_checked++;
                if (want.zero_norm) zero_norm_seen++;
                if (m_data.quat_w !== want.quat_w || m_data.quat_x !== want.quat_x ||
                    m_data.quat_y !== want.quat_y || m_data.quat_z !== want.quat_z ||
                    m_data.zero_norm !== want.zero_norm) begin
                    mismatch_count++;
                    if (mismatch_count + orphan_count <= MAX_REPORTS) begin
                        $display("mismatch at result %0d: exp w=%h x=%h y=%h z=%h zn=%b",
                                 results_checked, want.quat_w, want.quat_x, want.quat_y,
                                 want.quat_z, want.zero_norm);
                        $display("                       got w=%h x=%h y=%h z=%h zn=%b",
                                 m_data.quat_w, m_data.quat_x, m_data.quat_y,
                                 m_data.quat_z, m_data.zero_norm);
                    end
                end
            end
        end
    end

    // Watchdog: give up on a hang.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_quats.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        m_ready         = 1'b0;
        cycle_count     = 0;
        mismatch_count  = 0;
        orphan_count    = 0;
        items_sent      = 0;
        results_checked = 0;
        zero_norm_seen  = 0;
        hold_off_cycles = 0;
        attitude[0]     = qoi_pkg::Q_ONE;
        attitude[1]     = '0;
        attitude[2]     = '0;
        attitude[3]     = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_receiver_hold_off();
        test_sender_pause();
        test_random_stream(1780);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d commands, %0d results checked, %0d with skipped normalization",
                 items_sent, results_checked, zero_norm_seen);
        $display("including saturation corners, a long receiver stall and a drained pause");
        if (mismatch_count == 0 && orphan_count == 0 && expected_quats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d unexpected, %0d missing", mismatch_count,
                     orphan_count, expected_quats.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
